// ----- design/hse_pkg.sv -----
// hse_pkg: shared constants, types and sequencer states of the heap sort engine.
// No dependencies; compile first.
package hse_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  // child index 2*pos+1 needs one bit more than an address
  localparam int unsigned CH_W   = ADDR_W + 1;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [CH_W-1:0]          child_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BUILD,
    ST_HOLD,
    ST_CHILD,
    ST_C1,
    ST_C2,
    ST_SORT,
    ST_SWAP1,
    ST_SWAP2,
    ST_ORD,
    ST_OWAIT
  } st_t;

endpackage

// ----- design/hse_if.sv -----
// hse_if: valid/ready channel interfaces for the heap sort engine.
// Depends on hse_pkg.
interface hse_in_if;
  logic              valid;
  logic              ready;
  hse_pkg::data_t    value;
  logic              is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface hse_out_if;
  logic              valid;
  logic              ready;
  hse_pkg::data_t    sorted_value;
  logic              last_out;
  logic              dropped;

  modport source (output valid, output sorted_value, output last_out, output dropped,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input dropped,
                  output ready);
endinterface

// ----- design/hse_ram.sv -----
// hse_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module hse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/heap_sort_engine_unit.sv -----
// Channel   Dir  Payload                              Transaction
// in_ch     in   value[31:0] signed, is_last          valid & ready
// out_ch    out  sorted_value[31:0], last_out, dropped valid & ready
//
// Loading takes one item per cycle. The sort runs on one RAM with one read port:
// a sift reads the first child, then the second if present, and moves the larger
// one up while it beats the held value; results leave one per out_ch handshake.
// in_ready is high only while loading; a finished last result may still wait.
// rst_n is synchronous; the store needs no clearing pass.
// Depends on hse_pkg, hse_if, hse_ram.
module heap_sort_engine_unit (
  input  logic             clk,
  input  logic             rst_n,
  hse_in_if.sink           in_ch,
  hse_out_if.source        out_ch
);

  hse_pkg::st_t    state_r, state_nxt;
  hse_pkg::cnt_t   cnt_r, cnt_nxt;
  hse_pkg::cnt_t   k_r, k_nxt;
  hse_pkg::cnt_t   size_r, size_nxt;
  hse_pkg::addr_t  pos_r, pos_nxt;
  hse_pkg::addr_t  oidx_r, oidx_nxt;
  logic            ovf_r, ovf_nxt;
  logic            phase_r, phase_nxt;
  logic            out_valid_r, out_valid_nxt;
  hse_pkg::data_t  hold_r, hold_nxt;
  hse_pkg::data_t  cval_r, cval_nxt;
  hse_pkg::data_t  out_data_r;
  logic            out_last_r;
  logic            out_drop_r;

  logic            ram_we;
  hse_pkg::addr_t  ram_waddr;
  hse_pkg::data_t  ram_wdata;
  hse_pkg::addr_t  ram_raddr;
  logic [hse_pkg::DATA_W-1:0] ram_rdata;
  hse_pkg::data_t  rd_s;

  hse_pkg::child_t child;
  logic            child_ok;
  logic            has_c2;
  logic            c2_gt;
  hse_pkg::data_t  best_val;
  hse_pkg::addr_t  best_idx;
  logic            move_up;
  logic            in_acc;
  logic            store_ok;
  logic            out_load;
  logic            o_last;
  hse_pkg::st_t    ret_st;

  hse_ram #(
    .WIDTH (hse_pkg::DATA_W),
    .DEPTH (hse_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_s     = ram_rdata;
  assign child    = {pos_r, 1'b1};
  assign child_ok = child < hse_pkg::CH_W'(size_r);
  assign has_c2   = (child + hse_pkg::CH_W'(1)) < hse_pkg::CH_W'(size_r);
  assign c2_gt    = rd_s > cval_r;
  assign best_val = (state_r == hse_pkg::ST_C2 && !c2_gt) ? cval_r : rd_s;
  assign best_idx = (state_r == hse_pkg::ST_C2 && c2_gt)
                    ? hse_pkg::ADDR_W'(child + hse_pkg::CH_W'(1))
                    : hse_pkg::ADDR_W'(child);
  assign move_up  = best_val > hold_r;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign store_ok = cnt_r < hse_pkg::CNT_W'(hse_pkg::DEPTH);
  assign out_load = (state_r == hse_pkg::ST_OWAIT) && (!out_valid_r || out_ch.ready);
  assign o_last   = oidx_r == hse_pkg::ADDR_W'(cnt_r - 1'b1);
  assign ret_st   = phase_r ? hse_pkg::ST_SORT : hse_pkg::ST_BUILD;

  assign in_ch.ready         = (state_r == hse_pkg::ST_LOAD);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_data_r;
  assign out_ch.last_out     = out_last_r;
  assign out_ch.dropped      = out_drop_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hse_pkg::ST_LOAD: begin
        if (in_acc && in_ch.is_last) state_nxt = hse_pkg::ST_BUILD;
      end
      hse_pkg::ST_BUILD: begin
        state_nxt = (k_r == '0) ? hse_pkg::ST_SORT : hse_pkg::ST_HOLD;
      end
      hse_pkg::ST_HOLD:  state_nxt = hse_pkg::ST_CHILD;
      hse_pkg::ST_CHILD: begin
        state_nxt = child_ok ? hse_pkg::ST_C1 : ret_st;
      end
      hse_pkg::ST_C1: begin
        if (has_c2)       state_nxt = hse_pkg::ST_C2;
        else if (move_up) state_nxt = hse_pkg::ST_CHILD;
        else              state_nxt = ret_st;
      end
      hse_pkg::ST_C2: begin
        state_nxt = move_up ? hse_pkg::ST_CHILD : ret_st;
      end
      hse_pkg::ST_SORT: begin
        state_nxt = (k_r <= hse_pkg::CNT_W'(1)) ? hse_pkg::ST_ORD : hse_pkg::ST_SWAP1;
      end
      hse_pkg::ST_SWAP1: state_nxt = hse_pkg::ST_SWAP2;
      hse_pkg::ST_SWAP2: state_nxt = hse_pkg::ST_CHILD;
      hse_pkg::ST_ORD:   state_nxt = hse_pkg::ST_OWAIT;
      hse_pkg::ST_OWAIT: begin
        if (out_load) state_nxt = o_last ? hse_pkg::ST_LOAD : hse_pkg::ST_ORD;
      end
      default: state_nxt = hse_pkg::ST_LOAD;
    endcase
  end

  // memory accesses and register updates
  always_comb begin
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    size_nxt      = size_r;
    pos_nxt       = pos_r;
    oidx_nxt      = oidx_r;
    ovf_nxt       = ovf_r;
    phase_nxt     = phase_r;
    hold_nxt      = hold_r;
    cval_nxt      = cval_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = hold_r;
    ram_raddr     = oidx_r;
    case (state_r)
      hse_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (store_ok) begin
            ram_we    = 1'b1;
            ram_waddr = hse_pkg::ADDR_W'(cnt_r);
            ram_wdata = in_ch.value;
            cnt_nxt   = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.is_last) begin
            size_nxt  = cnt_nxt;
            k_nxt     = cnt_nxt >> 1;
            phase_nxt = 1'b0;
          end
        end
      end
      hse_pkg::ST_BUILD: begin
        if (k_r == '0) begin
          k_nxt     = cnt_r;
          phase_nxt = 1'b1;
        end else begin
          ram_raddr = hse_pkg::ADDR_W'(k_r - 1'b1);
          pos_nxt   = hse_pkg::ADDR_W'(k_r - 1'b1);
          k_nxt     = k_r - 1'b1;
        end
      end
      hse_pkg::ST_HOLD: hold_nxt = rd_s;
      hse_pkg::ST_CHILD: begin
        if (child_ok) begin
          ram_raddr = hse_pkg::ADDR_W'(child);
        end else begin
          ram_we = 1'b1;
        end
      end
      hse_pkg::ST_C1, hse_pkg::ST_C2: begin
        if (state_r == hse_pkg::ST_C1 && has_c2) begin
          cval_nxt  = rd_s;
          ram_raddr = hse_pkg::ADDR_W'(child + hse_pkg::CH_W'(1));
        end else if (move_up) begin
          ram_we    = 1'b1;
          ram_wdata = best_val;
          pos_nxt   = best_idx;
        end else begin
          ram_we = 1'b1;
        end
      end
      hse_pkg::ST_SORT: begin
        ram_raddr = '0;
        oidx_nxt  = '0;
      end
      hse_pkg::ST_SWAP1: begin
        cval_nxt  = rd_s;
        ram_raddr = hse_pkg::ADDR_W'(k_r - 1'b1);
      end
      hse_pkg::ST_SWAP2: begin
        // old root goes to the tail; the tail value sifts down from the root
        hold_nxt  = rd_s;
        ram_we    = 1'b1;
        ram_waddr = hse_pkg::ADDR_W'(k_r - 1'b1);
        ram_wdata = cval_r;
        size_nxt  = k_r - 1'b1;
        k_nxt     = k_r - 1'b1;
        pos_nxt   = '0;
      end
      hse_pkg::ST_ORD: ram_raddr = oidx_r;
      hse_pkg::ST_OWAIT: begin
        ram_raddr = oidx_r;
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (o_last) begin
            cnt_nxt  = '0;
            ovf_nxt  = 1'b0;
            oidx_nxt = '0;
          end else begin
            oidx_nxt = oidx_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hse_pkg::ST_LOAD;
      cnt_r       <= '0;
      k_r         <= '0;
      size_r      <= '0;
      pos_r       <= '0;
      oidx_r      <= '0;
      ovf_r       <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      size_r      <= size_nxt;
      pos_r       <= pos_nxt;
      oidx_r      <= oidx_nxt;
      ovf_r       <= ovf_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    cval_r <= cval_nxt;
    if (out_load) begin
      out_data_r <= rd_s;
      out_last_r <= o_last;
      out_drop_r <= ovf_r;
    end
  end

endmodule

// ----- design/hse_checker.sv -----
// hse_checker: port-level assertions for heap_sort_engine_unit, with its bind.
// Depends on heap_sort_engine_unit and hse_pkg.
module hse_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           in_is_last,
  input logic           out_valid,
  input logic           out_ready,
  input hse_pkg::data_t out_sorted_value,
  input logic           out_last_out,
  input logic           out_dropped
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sorted_value) && $stable(out_last_out)
                                && $stable(out_dropped))
    else $error("result payload changed while stalled");

  // the final item of a set starts the sort, which closes the input
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_last |=> !in_ready)
    else $error("input still open after end of set");

  // loading continues until the final item
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_is_last |=> in_ready)
    else $error("input closed in the middle of a set");

endmodule

bind heap_sort_engine_unit hse_checker u_hse_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_is_last       (in_ch.is_last),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_sorted_value (out_ch.sorted_value),
  .out_last_out     (out_ch.last_out),
  .out_dropped      (out_ch.dropped)
);
